@@ src/assert_macros.svh @@
// assertion macros used by the back end module (abdf_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ABDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ABDF_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ABDF_ASSERT(lbl, clk, rstn, prop)
`define ABDF_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ src/abdf_pkg.sv @@
// shared types, constants and helper functions of the anchor box decoder
package abdf_pkg;

  localparam int GRID_SIZE_DEF   = 512;
  localparam int LEVEL_COUNT_DEF = 6;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_THR  = 2'd0,
    CFG_CVAR = 2'd1,
    CFG_SVAR = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] THR_RST  = 16'd3277;
  localparam logic [15:0] CVAR_RST = 16'd6554;
  localparam logic [15:0] SVAR_RST = 16'd13107;

  // log2(e) in q.24
  localparam logic signed [25:0] LOG2E_Q24 = 26'sd24204406;

  localparam int EXP_STEPS = 16;
  localparam int EXP_LAT   = EXP_STEPS + 1;
  localparam int Q_W       = 17;
  localparam int DIV_LAT   = Q_W;

  localparam logic [46:0] EXP_CAP   = 47'd1 << 46;
  localparam logic [40:0] WIDTH_CAP = 41'd1 << 40;

  typedef struct packed {
    logic [2:0]         level;
    logic [8:0]         row;
    logic [8:0]         col;
    logic signed [15:0] bg;
    logic signed [15:0] fc;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] ow;
    logic signed [15:0] oh;
  } item_t;

  typedef struct packed {
    logic [15:0] thr;
    logic [15:0] cvar;
    logic [15:0] svar;
  } cfg_t;

  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] top;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
    logic [15:0]        score;
  } res_t;

  // 2^(2^-(k+1)) in q1.30
  function automatic logic [30:0] root_q30(input int k);
    logic [30:0] r;
    case (k)
      0:       r = 31'd1518500250;
      1:       r = 31'd1276901417;
      2:       r = 31'd1170923762;
      3:       r = 31'd1121280436;
      4:       r = 31'd1097253708;
      5:       r = 31'd1085434106;
      6:       r = 31'd1079572136;
      7:       r = 31'd1076653033;
      8:       r = 31'd1075196444;
      9:       r = 31'd1074468888;
      10:      r = 31'd1074105295;
      11:      r = 31'd1073923544;
      12:      r = 31'd1073832680;
      13:      r = 31'd1073787251;
      14:      r = 31'd1073764537;
      15:      r = 31'd1073753181;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

  // clamp to the 18 bit coordinate range
  function automatic logic signed [17:0] sat18(input logic signed [43:0] v);
    logic signed [17:0] r;
    if (v > 44'sd131071) begin
      r = 18'sd131071;
    end else if (v < -44'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

endpackage

@@ src/abdf_front.sv @@
// front end: accepts cells, drops out of range ones, queues the rest
module abdf_front import abdf_pkg::*; #(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       in_range, wr, rd;

  // range check of the incoming cell
  assign in_range = (int'(item_i.level) < LEVEL_COUNT) &&
                    (int'(item_i.row) < GRID_SIZE) &&
                    (int'(item_i.col) < GRID_SIZE);

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rd_ptr_q];
  assign wr      = push_i && !full_o && in_range;
  assign rd      = pop_i && valid_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/abdf_exp2.sv @@
// pipelined 2^(t/65536) in q.16, one root multiply per stage
module abdf_exp2 import abdf_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [26:0] t_i,
  output logic [46:0]        e_o
);

  logic [31:0]        m_q [EXP_STEPS];
  logic [15:0]        f_q [EXP_STEPS];
  logic signed [10:0] n_q [EXP_STEPS];
  logic [46:0]        e_q, e_d;

  // fraction bits, msb first
  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_step
    logic [31:0]        m_in;
    logic [15:0]        f_in;
    logic signed [10:0] n_in;
    logic [63:0]        prod;

    if (k == 0) begin : g_first
      assign m_in = 32'h4000_0000;
      assign f_in = t_i[15:0];
      assign n_in = t_i[26:16];
    end else begin : g_next
      assign m_in = m_q[k-1];
      assign f_in = f_q[k-1];
      assign n_in = n_q[k-1];
    end

    assign prod = 64'(m_in) * 64'(root_q30(k)) + (64'd1 << 29);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k] <= f_in[EXP_STEPS-1-k] ? prod[61:30] : m_in;
        f_q[k] <= f_in;
        n_q[k] <= n_in;
      end
    end
  end

  // integer part: shift with rounding, cap at 2^46
  always_comb begin
    logic signed [11:0] sh;
    logic [11:0]        s;
    logic [47:0]        r;
    logic [32:0]        rr;
    sh = $signed({n_q[EXP_STEPS-1][10], n_q[EXP_STEPS-1]}) - 12'sd14;
    s  = 12'(-sh);
    r  = 48'(m_q[EXP_STEPS-1]) << sh[3:0];
    rr = (33'(m_q[EXP_STEPS-1]) + (33'd1 << 5'(s[4:0] - 5'd1))) >> s[4:0];
    if (!sh[11]) begin
      if (sh > 12'sd15) begin
        e_d = EXP_CAP;
      end else if (r > 48'(EXP_CAP)) begin
        e_d = EXP_CAP;
      end else begin
        e_d = r[46:0];
      end
    end else if (s >= 12'd32) begin
      e_d = '0;
    end else begin
      e_d = 47'(rr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

@@ src/abdf_div.sv @@
// pipelined restoring divider for round(2^32 / den), one quotient bit per stage
module abdf_div import abdf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [47:0]      den_i,
  output logic [Q_W-1:0]   quo_o
);

  logic [48:0]    rem_q [Q_W];
  logic [47:0]    den_q [Q_W];
  logic [Q_W-1:0] quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int B = Q_W - 1 - k;
    logic [48:0]    r_in;
    logic [47:0]    d_in;
    logic [Q_W-1:0] q_in;
    logic [63:0]    dsh;
    logic           ge;

    if (k == 0) begin : g_first
      // numerator carries the rounding half of the divisor
      assign r_in = (49'd1 << 32) + 49'(den_i >> 1);
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign dsh = 64'(d_in) << B;
    assign ge  = (64'(r_in) >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (r_in - dsh[48:0]) : r_in;
        den_q[k] <= d_in;
        quo_q[k] <= ge ? (q_in | (Q_W'(1) << B)) : q_in;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

@@ src/abdf_back.sv @@
// back end: score and box pipeline with its result queue
`include "assert_macros.svh"
module abdf_back import abdf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  input  item_t item_i,
  output logic  in_pop_o,
  input  logic  out_pop_i,
  output logic  out_empty_o,
  output res_t  res_o
);

  localparam int T_STG = 3;
  localparam int E_STG = T_STG + EXP_LAT;
  localparam int B_STG = E_STG + 2;
  localparam int P_STG = E_STG + DIV_LAT;

  typedef struct packed {
    logic [2:0]         level;
    logic [8:0]         row;
    logic [8:0]         col;
    logic signed [32:0] px;
    logic signed [32:0] py;
  } side_t;

  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] top;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
  } box_t;

  logic             en, take;
  logic [P_STG:1]   vld_q;

  logic signed [42:0] ps_q;
  logic signed [32:0] pw_q, ph_q;
  logic signed [26:0] ts2_q, ts3_q, tw_q, th_q;
  logic signed [58:0] qw_q, qh_q;
  side_t              side_q [E_STG:1];
  logic [46:0]        e_s, e_w, e_h;
  logic signed [27:0] cxd_q, cyd_q, cxd_d, cyd_d;
  logic [40:0]        w_q, h_q, w_d, h_d;
  box_t               box_q [P_STG:B_STG];
  box_t               box_d;
  logic [Q_W-1:0]     quo;
  logic [15:0]        score;
  logic               keep;

  res_t               oent_q [2];
  logic               owr_ptr_q, ord_ptr_q;
  logic [1:0]         ocnt_q;
  logic               out_wr, out_rd;

  // pipeline advances unless the result queue is full and a result waits
  assign en       = (ocnt_q != 2'd2) || !vld_q[P_STG];
  assign take     = en && in_valid_i;
  assign in_pop_o = take;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[P_STG-1:1], in_valid_i};
    end
  end

  // exponent arguments, three stages
  always_ff @(posedge clk_i) begin
    logic signed [16:0] dt;
    logic signed [42:0] psr;
    logic signed [58:0] qwr, qhr;
    if (en) begin
      dt    = $signed({item_i.bg[15], item_i.bg}) - $signed({item_i.fc[15], item_i.fc});
      ps_q  <= dt * LOG2E_Q24;
      pw_q  <= item_i.ow * $signed({1'b0, cfg_i.svar});
      ph_q  <= item_i.oh * $signed({1'b0, cfg_i.svar});
      psr   = ps_q + 43'sd32768;
      ts2_q <= psr[42:16];
      qw_q  <= pw_q * LOG2E_Q24;
      qh_q  <= ph_q * LOG2E_Q24;
      ts3_q <= ts2_q;
      qwr   = qw_q + 59'sd2147483648;
      qhr   = qh_q + 59'sd2147483648;
      tw_q  <= qwr[58:32];
      th_q  <= qhr[58:32];
    end
  end

  // cell position and centre products ride along the exponent units
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1].level <= item_i.level;
      side_q[1].row   <= item_i.row;
      side_q[1].col   <= item_i.col;
      side_q[1].px    <= item_i.ox * $signed({1'b0, cfg_i.cvar});
      side_q[1].py    <= item_i.oy * $signed({1'b0, cfg_i.cvar});
      for (int k = 2; k <= E_STG; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  abdf_exp2 u_exp_s (.clk_i(clk_i), .en_i(en), .t_i(ts3_q), .e_o(e_s));
  abdf_exp2 u_exp_w (.clk_i(clk_i), .en_i(en), .t_i(tw_q),  .e_o(e_w));
  abdf_exp2 u_exp_h (.clk_i(clk_i), .en_i(en), .t_i(th_q),  .e_o(e_h));

  abdf_div u_div (
    .clk_i(clk_i),
    .en_i (en),
    .den_i({1'b0, e_s} + 48'd65536),
    .quo_o(quo)
  );

  // anchor centre plus offset, and scaled size
  always_comb begin
    logic [3:0]         sh8, sh5;
    logic [63:0]        ews, ehs;
    logic signed [49:0] pxs, pys;
    logic signed [25:0] dx, dy;
    logic [22:0]        cxa, cya;
    sh8 = 4'(side_q[E_STG].level) + 4'd8;
    sh5 = 4'(side_q[E_STG].level) + 4'd5;
    ews = (64'(e_w) << sh8) + 64'd32768;
    ehs = (64'(e_h) << sh8) + 64'd32768;
    w_d = (ews[63:16] > 48'(WIDTH_CAP)) ? WIDTH_CAP : ews[56:16];
    h_d = (ehs[63:16] > 48'(WIDTH_CAP)) ? WIDTH_CAP : ehs[56:16];
    pxs = (50'(side_q[E_STG].px) <<< sh8) + 50'sd8388608;
    pys = (50'(side_q[E_STG].py) <<< sh8) + 50'sd8388608;
    dx  = pxs[49:24];
    dy  = pys[49:24];
    cxa = 23'({side_q[E_STG].col, 1'b1}) << sh5;
    cya = 23'({side_q[E_STG].row, 1'b1}) << sh5;
    cxd_d = $signed({5'b0, cxa}) + 28'(dx);
    cyd_d = $signed({5'b0, cya}) + 28'(dy);
  end

  // corners with saturation
  always_comb begin
    logic [40:0] wr_half, hr_half;
    wr_half = w_q - {1'b0, w_q[40:1]};
    hr_half = h_q - {1'b0, h_q[40:1]};
    box_d.left   = sat18(44'(cxd_q) - $signed({4'b0, w_q[40:1]}));
    box_d.top    = sat18(44'(cyd_q) - $signed({4'b0, h_q[40:1]}));
    box_d.right  = sat18(44'(cxd_q) + $signed({3'b0, wr_half}));
    box_d.bottom = sat18(44'(cyd_q) + $signed({3'b0, hr_half}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cxd_q        <= cxd_d;
      cyd_q        <= cyd_d;
      w_q          <= w_d;
      h_q          <= h_d;
      box_q[B_STG] <= box_d;
      for (int k = B_STG + 1; k <= P_STG; k++) begin
        box_q[k] <= box_q[k-1];
      end
    end
  end

  // score cap and threshold
  assign score  = quo[Q_W-1] ? 16'hFFFF : quo[15:0];
  assign keep   = (score >= cfg_i.thr);
  assign out_wr = en && vld_q[P_STG] && keep;
  assign out_rd = out_pop_i && (ocnt_q != 2'd0);

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_ptr_q <= 1'b0;
      ord_ptr_q <= 1'b0;
      ocnt_q    <= 2'd0;
    end else begin
      if (out_wr) begin
        owr_ptr_q <= !owr_ptr_q;
      end
      if (out_rd) begin
        ord_ptr_q <= !ord_ptr_q;
      end
      if (out_wr && !out_rd) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (out_rd && !out_wr) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      oent_q[owr_ptr_q].left   <= box_q[P_STG].left;
      oent_q[owr_ptr_q].top    <= box_q[P_STG].top;
      oent_q[owr_ptr_q].right  <= box_q[P_STG].right;
      oent_q[owr_ptr_q].bottom <= box_q[P_STG].bottom;
      oent_q[owr_ptr_q].score  <= score;
    end
  end

  assign out_empty_o = (ocnt_q == 2'd0);
  assign res_o       = oent_q[ord_ptr_q];

  // checks
  `ABDF_ASSERT(a_out_no_overflow, clk_i, rst_ni, out_wr |-> (ocnt_q != 2'd2))
  `ABDF_ASSERT(a_stall_holds_pipe, clk_i, rst_ni, !en |=> $stable(vld_q))
  `ABDF_ASSERT(a_full_stays_full, clk_i, rst_ni, (ocnt_q == 2'd2 && vld_q[P_STG] && !out_rd) |=> !en)
  `ABDF_NEVER(a_out_cnt_range, clk_i, rst_ni, ocnt_q == 2'd3)

endmodule

@@ src/anchor_box_decode_filter_unit.sv @@
// Anchor box decoder: scores one detector cell per cycle and emits its face box,
// unless a full result queue stalls it. A cell is taken on every cycle that full
// is low. Its box comes out of the 16 step exponent pipeline (one root multiply a
// stage) followed by the 17 stage score divider (one quotient bit a stage), and
// the rate is one cell per clock while no stall holds. Cells outside the level
// or grid range and cells whose face score is below the threshold give no word.
module anchor_box_decode_filter_unit import abdf_pkg::*; #(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         level_i,
  input  logic [8:0]         row_i,
  input  logic [8:0]         col_i,
  input  logic signed [15:0] background_logit_i,
  input  logic signed [15:0] face_logit_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic signed [15:0] offset_w_i,
  input  logic signed [15:0] offset_h_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [17:0] left_o,
  output logic signed [17:0] top_o,
  output logic signed [17:0] right_o,
  output logic signed [17:0] bottom_o,
  output logic [15:0]        face_score_o
);

  cfg_t  cfg_q;
  item_t in_item, fq_item;
  logic  fq_valid, fq_pop;
  res_t  res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr  <= THR_RST;
      cfg_q.cvar <= CVAR_RST;
      cfg_q.svar <= SVAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THR:  cfg_q.thr  <= cfg_data_i;
        CFG_CVAR: cfg_q.cvar <= cfg_data_i;
        CFG_SVAR: cfg_q.svar <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word
  always_comb begin
    in_item.level = level_i;
    in_item.row   = row_i;
    in_item.col   = col_i;
    in_item.bg    = background_logit_i;
    in_item.fc    = face_logit_i;
    in_item.ox    = offset_x_i;
    in_item.oy    = offset_y_i;
    in_item.ow    = offset_w_i;
    in_item.oh    = offset_h_i;
  end

  abdf_front #(
    .GRID_SIZE  (GRID_SIZE),
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .item_i (in_item),
    .pop_i  (fq_pop),
    .valid_o(fq_valid),
    .item_o (fq_item)
  );

  abdf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (fq_valid),
    .item_i     (fq_item),
    .in_pop_o   (fq_pop),
    .out_pop_i  (pop),
    .out_empty_o(empty),
    .res_o      (res)
  );

  assign left_o       = res.left;
  assign top_o        = res.top;
  assign right_o      = res.right;
  assign bottom_o     = res.bottom;
  assign face_score_o = res.score;

endmodule

@@ sim/tb.sv @@
// self-checking testbench of the anchor box decoder: random and corner cells vs a local predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import abdf_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped register index
  localparam int LEVELS   = 6;
  localparam int LATENCY  = 60;
  localparam int LIMIT    = 600000;

  // box scoreboard: predicts the decoded box of each accepted cell
  class box_board;
    res_t box_q[$];
    cfg_t regs;
    longint unsigned roots[16];
    int mismatches;
    int cells;
    int boxes;

    function new();
      roots = '{64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
                64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033,
                64'd1075196444, 64'd1074468888, 64'd1074105295, 64'd1073923544,
                64'd1073832680, 64'd1073787251, 64'd1073764537, 64'd1073753181};
      regs = '{thr: THR_RST, cvar: CVAR_RST, svar: SVAR_RST};
      mismatches = 0;
      cells = 0;
      boxes = 0;
    endfunction

    // 2^(t/65536) in q.16, capped at 2^46
    function longint unsigned pow2_q16(longint t);
      longint unsigned f;
      longint unsigned m;
      longint sh;
      longint unsigned r;
      f = t & 64'hFFFF;
      m = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        if (f[15-k]) m = (m * roots[k] + (64'd1 << 29)) >> 30;
      end
      sh = (t >>> 16) - 14;
      if (sh >= 0) begin
        if (sh > 15) return 64'd1 << 46;
        r = m << sh;
        return (r > (64'd1 << 46)) ? (64'd1 << 46) : r;
      end
      if (-sh >= 32) return 64'd0;
      return (m + (64'd1 << (-sh - 1))) >> (-sh);
    endfunction

    // anchor size times exp(offset * size variance), capped at 2^40
    function longint stretch(longint off, longint size);
      longint t;
      longint unsigned w;
      t = (off * longint'(regs.svar) * 64'sd24204406 + (64'sd1 <<< 31)) >>> 32;
      w = (longint'(size) * pow2_q16(t) + 64'd32768) >> 16;
      return (w > (64'd1 << 40)) ? (64'sd1 <<< 40) : longint'(w);
    endfunction

    function logic signed [17:0] clamp18(longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return -18'sd131072;
      return v[17:0];
    endfunction

    // accepted cell: queue its box if it is in range and scores high enough
    function void note_cell(item_t c);
      longint unsigned e;
      longint unsigned den;
      longint unsigned p;
      longint s16;
      longint size;
      longint cx;
      longint cy;
      longint w;
      longint h;
      longint lft;
      longint tp;
      res_t b;
      if (c.level >= LEVELS) return;
      cells++;
      e = pow2_q16(((longint'(c.bg) - longint'(c.fc)) * 64'sd24204406 + 64'sd32768) >>> 16);
      den = 64'd65536 + e;
      p = ((64'd1 << 32) + den / 2) / den;
      if (p > 65535) p = 65535;
      if (p < regs.thr) return;
      s16 = 64'sd16 <<< (c.level + 2);
      size = 4 * s16;
      cx = longint'(c.col) * s16 + s16 / 2;
      cy = longint'(c.row) * s16 + s16 / 2;
      cx += (longint'(c.ox) * longint'(regs.cvar) * size + (64'sd1 <<< 23)) >>> 24;
      cy += (longint'(c.oy) * longint'(regs.cvar) * size + (64'sd1 <<< 23)) >>> 24;
      w = stretch(longint'(c.ow), size);
      h = stretch(longint'(c.oh), size);
      lft = cx - w / 2;
      tp = cy - h / 2;
      b.left = clamp18(lft);
      b.top = clamp18(tp);
      b.right = clamp18(lft + w);
      b.bottom = clamp18(tp + h);
      b.score = p[15:0];
      box_q = {box_q, b};
    endfunction

    function void miss(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
    endfunction

    // popped word: compare with the oldest expected box
    function void check_box(res_t got);
      res_t want;
      if (box_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected box word, score %0d", got.score);
        return;
      end
      want = box_q.pop_front();
      boxes++;
      if (got.left !== want.left) miss("left", want.left, got.left);
      if (got.top !== want.top) miss("top", want.top, got.top);
      if (got.right !== want.right) miss("right", want.right, got.right);
      if (got.bottom !== want.bottom) miss("bottom", want.bottom, got.bottom);
      if (got.score !== want.score) miss("face_score", want.score, got.score);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic push, full, empty, pop;
  item_t drv_item;
  logic signed [17:0] left_o, top_o, right_o, bottom_o;
  logic [15:0] face_score_o;

  box_board sb = new();
  int cycles = 0;
  int burst_left = 0;
  int reg_writes = 0;
  int sink_mode = 0;

  anchor_box_decode_filter_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .push(push), .full(full),
    .level_i(drv_item.level), .row_i(drv_item.row), .col_i(drv_item.col),
    .background_logit_i(drv_item.bg), .face_logit_i(drv_item.fc),
    .offset_x_i(drv_item.ox), .offset_y_i(drv_item.oy),
    .offset_w_i(drv_item.ow), .offset_h_i(drv_item.oh),
    .empty(empty), .pop(pop),
    .left_o(left_o), .top_o(top_o), .right_o(right_o), .bottom_o(bottom_o),
    .face_score_o(face_score_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // word monitors on both sides
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_cell(drv_item);
    if (rst_ni && pop && !empty) sb.check_box('{left_o, top_o, right_o, bottom_o, face_score_o});
  end

  // receiver stall pattern: free run, light stalls, or long stalls
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) sink_mode <= $urandom_range(0, 2);
    case (sink_mode)
      0: begin
        pop <= 1'b1;
      end
      1: begin
        pop <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        pop <= ($urandom_range(0, 9) == 0);
      end
    endcase
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_cell(item_t c);
    push <= 1'b1;
    drv_item <= c;
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.box_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // write all registers while idle, with one write to the spare index
  task automatic set_regs(logic [15:0] thr, logic [15:0] cvar, logic [15:0] svar);
    logic [15:0] junk;
    drain();
    junk = 16'($urandom);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_THR;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CVAR;
    cfg_data_i <= cvar;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SVAR;
    cfg_data_i <= svar;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SPARE;
    cfg_data_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.regs = '{thr: thr, cvar: cvar, svar: svar};
    reg_writes += 4;
  endtask

  function automatic item_t make_cell(int lvl, int r, int c, int b, int f, int o);
    item_t x;
    x.level = 3'(lvl);
    x.row = 9'(r);
    x.col = 9'(c);
    x.bg = 16'(b);
    x.fc = 16'(f);
    x.ox = 16'(o);
    x.oy = 16'(-o);
    x.ow = 16'(o);
    x.oh = 16'(-o);
    return x;
  endfunction

  function automatic item_t rand_cell();
    item_t x;
    x.level = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    x.row = 9'($urandom);
    x.col = 9'($urandom);
    x.bg = 16'($urandom);
    if ($urandom_range(0, 1)) x.fc = 16'($urandom);
    else x.fc = 16'(int'(x.bg) + int'($urandom_range(0, 2047)) - 1024);
    if ($urandom_range(0, 3) == 0) begin
      x.ox = 16'($urandom);
      x.oy = 16'($urandom);
      x.ow = 16'($urandom);
      x.oh = 16'($urandom);
    end else begin
      x.ox = 16'(int'($urandom_range(0, 1023)) - 512);
      x.oy = 16'(int'($urandom_range(0, 1023)) - 512);
      x.ow = 16'(int'($urandom_range(0, 1023)) - 512);
      x.oh = 16'(int'($urandom_range(0, 1023)) - 512);
    end
    return x;
  endfunction

  // random cells in bursts; ignored cells do not count
  task automatic run_cells(int n);
    item_t x;
    int gap;
    int sent;
    sent = 0;
    while (sent < n) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      x = rand_cell();
      if (x.level < LEVELS) sent++;
      send_cell(x);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    drv_item <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_THR;
    cfg_data_i <= '0;
    pop <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: level and grid extremes, logit extremes, big offsets, ignored levels
    send_cell(make_cell(0, 0, 0, 0, 0, 0));
    send_cell(make_cell(5, 511, 511, 0, 0, 0));
    send_cell(make_cell(6, 3, 3, 0, 0, 0));
    send_cell(make_cell(7, 3, 3, 0, 0, 0));
    send_cell(make_cell(2, 100, 50, -32768, 32767, 0));
    send_cell(make_cell(2, 100, 50, 32767, -32768, 0));
    send_cell(make_cell(5, 511, 0, 0, 0, 32767));
    send_cell(make_cell(5, 0, 511, 0, 0, -32768));
    send_cell(make_cell(0, 255, 255, 0, 0, 256));
    send_cell(make_cell(3, 7, 9, -512, 0, -256));
    set_regs(16'd0, 16'd65535, 16'd65535);
    send_cell(make_cell(0, 0, 0, 32767, -32768, 32767));
    send_cell(make_cell(5, 511, 511, 0, 0, 32767));
    send_cell(make_cell(4, 20, 30, 0, 0, -32768));
    send_cell(make_cell(1, 1, 1, 100, 0, 1000));
    // threshold at one half: equal logits pass, a tiny background lead does not
    set_regs(16'd32768, 16'd0, 16'd0);
    send_cell(make_cell(2, 5, 5, 0, 0, 300));
    send_cell(make_cell(2, 5, 5, 1, 0, 300));
    send_cell(make_cell(2, 5, 5, 0, 1, 300));
    set_regs(16'd65535, 16'd1, 16'd1);
    send_cell(make_cell(1, 4, 4, -32768, 32767, 5));
    send_cell(make_cell(1, 4, 4, 0, 0, 5));

    // random phases over several register settings
    set_regs(THR_RST, CVAR_RST, SVAR_RST);
    run_cells(400);
    drain();
    run_cells(300);
    set_regs(16'd0, 16'd65535, 16'd65535);
    run_cells(300);
    set_regs(16'd0, 16'd0, 16'd0);
    run_cells(250);
    set_regs(16'd45000, 16'($urandom), 16'($urandom));
    run_cells(250);
    set_regs(16'($urandom_range(0, 40000)), 16'($urandom), 16'($urandom));
    run_cells(400);
    drain();

    $display("covered %0d in-range cells, %0d boxes checked, %0d register writes",
             sb.cells, sb.boxes, reg_writes);
    if (sb.mismatches == 0 && sb.box_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d boxes missing", sb.mismatches, sb.box_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
